>>> src/dik_pkg.sv
package dik_pkg;

  localparam int NUM_TOWERS  = 3;
  localparam int COORD_W     = 17;
  localparam int HEIGHT_W    = 19;
  localparam int RADIUS_W    = 16;
  localparam int ROD_W       = 17;
  localparam int XOFS_W      = 17;
  localparam int YOFS_W      = 16;
  localparam int DIFF_W      = 18;
  localparam int SQ_W        = 34;
  localparam int ARG_W       = 36;
  localparam int ROOT_W      = 17;
  localparam int REM_W       = 20;
  localparam int SQRT_STAGES = 17;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [RADIUS_W-1:0] SIN60_Q16 = 16'd56756;
  localparam logic [XOFS_W:0]     ROUND_Q16 = 18'd32768;

  localparam logic [CFG_ADDR_W-1:0] REG_TOWER_RADIUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROD_LENGTH   = 2'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd23556;
  localparam logic [ROD_W-1:0]    ROD_RESET    = 17'd55296;

  localparam int TWR_A = 0;
  localparam int TWR_B = 1;
  localparam int TWR_C = 2;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic [SQ_W-1:0]            sq_t;
  typedef logic signed [ARG_W-1:0]    arg_t;
  typedef logic [NUM_TOWERS-1:0]      flags_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [XOFS_W-1:0]   x_ofs;
    logic [YOFS_W-1:0]   y_ofs;
    sq_t                 rod_sq;
  } geo_t;

  typedef struct packed {
    logic                       valid;
    flags_t                     neg;
    coord_t                     z;
    sq_t [NUM_TOWERS-1:0]       mag;
  } root_item_t;

  typedef struct packed {
    height_t [NUM_TOWERS-1:0]   carriage;
    flags_t                     unreachable;
  } result_t;

endpackage

>>> src/dik_intf.sv
interface dik_in_if import dik_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t target_x;
  coord_t target_y;
  coord_t target_z;

  modport source(output valid, output target_x, output target_y, output target_z,
                 input ready);
  modport sink(input valid, input target_x, input target_y, input target_z,
               output ready);
endinterface

interface dik_out_if import dik_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t carriage_a;
  height_t carriage_b;
  height_t carriage_c;
  flags_t  unreachable;

  modport source(output valid, output carriage_a, output carriage_b, output carriage_c,
                 output unreachable, input ready);
  modport sink(input valid, input carriage_a, input carriage_b, input carriage_c,
               input unreachable, output ready);
endinterface

interface dik_cfg_if import dik_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output addr, output data, input ready);
  modport sink(input valid, input addr, input data, output ready);
endinterface

>>> src/delta_inverse_kinematics.sv
// A target passes the geometry registers s1, s2, s3 and item, the root stages, then the rounding and output registers.
// Throughput: one target per cycle; the whole pipeline freezes while the
// result waits for the sink, and in_ch.ready follows that stall.
// Root extraction is a 17-stage bit-per-stage pipeline, one lane per tower.
// Reset clears all valid bits and loads the default radius and rod length.
module delta_inverse_kinematics import dik_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dik_in_if.sink    in_ch,
  dik_out_if.source out_ch,
  dik_cfg_if.sink   cfg_ch
);

  geo_t       geo;
  root_item_t item;
  logic       res_vld;
  result_t    res;
  logic       advance;

  assign advance     = !res_vld || out_ch.ready;
  assign in_ch.ready = advance;

  dik_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .geo    (geo)
  );

  dik_geom u_geom (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .in_vld (in_ch.valid),
    .in_x   (in_ch.target_x),
    .in_y   (in_ch.target_y),
    .in_z   (in_ch.target_z),
    .geo    (geo),
    .item   (item)
  );

  dik_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_ch.valid       = res_vld;
  assign out_ch.carriage_a  = res.carriage[TWR_A];
  assign out_ch.carriage_b  = res.carriage[TWR_B];
  assign out_ch.carriage_c  = res.carriage[TWR_C];
  assign out_ch.unreachable = res.unreachable;

endmodule

>>> src/dik_cfg.sv
module dik_cfg import dik_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  dik_cfg_if.sink  cfg_ch,
  output geo_t     geo
);

  logic [RADIUS_W-1:0] radius_r;
  logic [ROD_W-1:0]    rod_r;
  geo_t                geo_r;
  geo_t                geo_nxt;
  logic [2*RADIUS_W-1:0] x_prod;
  logic [XOFS_W+RADIUS_W-1:0] x_sum;
  logic [RADIUS_W:0]   y_sum;
  logic [2*ROD_W-1:0]  rod_prod;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      rod_r    <= ROD_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.addr)
        REG_TOWER_RADIUS: radius_r <= cfg_ch.data[RADIUS_W-1:0];
        REG_ROD_LENGTH:   rod_r    <= cfg_ch.data[ROD_W-1:0];
        default: ;
      endcase
    end
  end

  assign x_prod   = {{RADIUS_W{1'b0}}, radius_r} * {{RADIUS_W{1'b0}}, SIN60_Q16};
  assign x_sum    = {1'b0, x_prod} + {{(XOFS_W+RADIUS_W-XOFS_W-1){1'b0}}, ROUND_Q16};
  assign y_sum    = {1'b0, radius_r} + {{RADIUS_W{1'b0}}, 1'b1};
  assign rod_prod = {{ROD_W{1'b0}}, rod_r} * {{ROD_W{1'b0}}, rod_r};

  always_comb begin
    geo_nxt.radius = radius_r;
    geo_nxt.x_ofs  = x_sum[XOFS_W+RADIUS_W-1:RADIUS_W];
    geo_nxt.y_ofs  = y_sum[RADIUS_W:1];
    geo_nxt.rod_sq = rod_prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    geo_r <= geo_nxt;
  end

  assign geo = geo_r;

endmodule

>>> src/dik_geom.sv
module dik_geom import dik_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  coord_t     in_x,
  input  coord_t     in_y,
  input  coord_t     in_z,
  input  geo_t       geo,
  output root_item_t item
);

  logic   s1_vld_r;
  coord_t s1_x_r;
  coord_t s1_y_r;
  coord_t s1_z_r;

  logic   s2_vld_r;
  diff_t  s2_dxa_r;
  diff_t  s2_dxb_r;
  diff_t  s2_dxc_r;
  diff_t  s2_dyab_r;
  diff_t  s2_dyc_r;
  coord_t s2_z_r;
  diff_t  dxa_nxt;
  diff_t  dxb_nxt;
  diff_t  dxc_nxt;
  diff_t  dyab_nxt;
  diff_t  dyc_nxt;

  logic   s3_vld_r;
  sq_t    s3_xa_r;
  sq_t    s3_xb_r;
  sq_t    s3_xc_r;
  sq_t    s3_yab_r;
  sq_t    s3_yc_r;
  coord_t s3_z_r;
  logic signed [2*DIFF_W-1:0] p_xa;
  logic signed [2*DIFF_W-1:0] p_xb;
  logic signed [2*DIFF_W-1:0] p_xc;
  logic signed [2*DIFF_W-1:0] p_yab;
  logic signed [2*DIFF_W-1:0] p_yc;

  arg_t       arg_a;
  arg_t       arg_b;
  arg_t       arg_c;
  arg_t       rod_ext;
  root_item_t item_r;
  root_item_t item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      item_r.valid <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      item_r.valid <= s3_vld_r;
    end
    if (en) begin
      item_r.z   <= item_nxt.z;
      item_r.neg <= item_nxt.neg;
      item_r.mag <= item_nxt.mag;
    end
  end

  assign dxa_nxt  = -$signed({1'b0, geo.x_ofs}) - diff_t'(s1_x_r);
  assign dxb_nxt  = $signed({1'b0, geo.x_ofs}) - diff_t'(s1_x_r);
  assign dxc_nxt  = -diff_t'(s1_x_r);
  assign dyab_nxt = -$signed({2'b00, geo.y_ofs}) - diff_t'(s1_y_r);
  assign dyc_nxt  = $signed({2'b00, geo.radius}) - diff_t'(s1_y_r);

  assign p_xa  = s2_dxa_r * s2_dxa_r;
  assign p_xb  = s2_dxb_r * s2_dxb_r;
  assign p_xc  = s2_dxc_r * s2_dxc_r;
  assign p_yab = s2_dyab_r * s2_dyab_r;
  assign p_yc  = s2_dyc_r * s2_dyc_r;

  assign rod_ext = $signed({2'b00, geo.rod_sq});
  assign arg_a   = rod_ext - $signed({2'b00, s3_xa_r}) - $signed({2'b00, s3_yab_r});
  assign arg_b   = rod_ext - $signed({2'b00, s3_xb_r}) - $signed({2'b00, s3_yab_r});
  assign arg_c   = rod_ext - $signed({2'b00, s3_xc_r}) - $signed({2'b00, s3_yc_r});

  always_comb begin
    item_nxt            = item_r;
    item_nxt.z          = s3_z_r;
    item_nxt.neg[TWR_A] = arg_a[ARG_W-1];
    item_nxt.neg[TWR_B] = arg_b[ARG_W-1];
    item_nxt.neg[TWR_C] = arg_c[ARG_W-1];
    item_nxt.mag[TWR_A] = arg_a[ARG_W-1] ? '0 : arg_a[SQ_W-1:0];
    item_nxt.mag[TWR_B] = arg_b[ARG_W-1] ? '0 : arg_b[SQ_W-1:0];
    item_nxt.mag[TWR_C] = arg_c[ARG_W-1] ? '0 : arg_c[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
      s1_z_r    <= in_z;
      s2_dxa_r  <= dxa_nxt;
      s2_dxb_r  <= dxb_nxt;
      s2_dxc_r  <= dxc_nxt;
      s2_dyab_r <= dyab_nxt;
      s2_dyc_r  <= dyc_nxt;
      s2_z_r    <= s1_z_r;
      s3_xa_r   <= p_xa[SQ_W-1:0];
      s3_xb_r   <= p_xb[SQ_W-1:0];
      s3_xc_r   <= p_xc[SQ_W-1:0];
      s3_yab_r  <= p_yab[SQ_W-1:0];
      s3_yc_r   <= p_yc[SQ_W-1:0];
      s3_z_r    <= s2_z_r;
    end
  end

  assign item = item_r;

endmodule

>>> src/dik_sqrt.sv
module dik_sqrt import dik_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  root_item_t item,
  output logic       res_vld,
  output result_t    res
);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    sq_t               rest;
  } lane_t;

  logic   it_vld_r  [SQRT_STAGES];
  lane_t  it_lane_r [SQRT_STAGES][NUM_TOWERS];
  coord_t it_z_r    [SQRT_STAGES];
  flags_t it_neg_r  [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic             src_vld;
    coord_t           src_z;
    flags_t           src_neg;
    lane_t            src       [NUM_TOWERS];
    lane_t            lane_nxt  [NUM_TOWERS];
    logic [REM_W-1:0] rem_shift [NUM_TOWERS];
    logic [REM_W-1:0] trial     [NUM_TOWERS];
    logic             take      [NUM_TOWERS];

    if (j == 0) begin : g_head
      assign src_vld = item.valid;
      assign src_z   = item.z;
      assign src_neg = item.neg;
      for (genvar t = 0; t < NUM_TOWERS; t++) begin : g_lane
        assign src[t] = '{rem: '0, root: '0, rest: item.mag[t]};
      end
    end else begin : g_body
      assign src_vld = it_vld_r[j-1];
      assign src_z   = it_z_r[j-1];
      assign src_neg = it_neg_r[j-1];
      for (genvar t = 0; t < NUM_TOWERS; t++) begin : g_lane
        assign src[t] = it_lane_r[j-1][t];
      end
    end

    for (genvar t = 0; t < NUM_TOWERS; t++) begin : g_step
      assign rem_shift[t] = {src[t].rem[REM_W-3:0], src[t].rest[SQ_W-1:SQ_W-2]};
      assign trial[t]     = {1'b0, src[t].root, 2'b01};
      assign take[t]      = (rem_shift[t] >= trial[t]);
      assign lane_nxt[t].rem  = take[t] ? (rem_shift[t] - trial[t]) : rem_shift[t];
      assign lane_nxt[t].root = {src[t].root[ROOT_W-2:0], take[t]};
      assign lane_nxt[t].rest = {src[t].rest[SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_vld_r[j] <= 1'b0;
      end else if (en) begin
        it_vld_r[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_z_r[j]   <= src_z;
        it_neg_r[j] <= src_neg;
        for (int t = 0; t < NUM_TOWERS; t++) begin
          it_lane_r[j][t] <= lane_nxt[t];
        end
      end
    end
  end

  logic              rnd_vld_r;
  logic [ROOT_W:0]   rnd_root_r [NUM_TOWERS];
  logic [ROOT_W:0]   rnd_root_nxt [NUM_TOWERS];
  coord_t            rnd_z_r;
  flags_t            rnd_neg_r;

  logic              out_vld_r;
  height_t           out_h_r [NUM_TOWERS];
  height_t           out_h_nxt [NUM_TOWERS];
  flags_t            out_flag_r;

  always_comb begin
    for (int t = 0; t < NUM_TOWERS; t++) begin
      rnd_root_nxt[t] = {1'b0, it_lane_r[SQRT_STAGES-1][t].root}
                      + {{ROOT_W{1'b0}},
                         (it_lane_r[SQRT_STAGES-1][t].rem >
                          {{(REM_W-ROOT_W){1'b0}}, it_lane_r[SQRT_STAGES-1][t].root})};
    end
  end

  always_comb begin
    for (int t = 0; t < NUM_TOWERS; t++) begin
      out_h_nxt[t] = rnd_neg_r[t] ? '0
                   : $signed({1'b0, rnd_root_r[t]}) + height_t'(rnd_z_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      rnd_vld_r <= it_vld_r[SQRT_STAGES-1];
      out_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_z_r    <= it_z_r[SQRT_STAGES-1];
      rnd_neg_r  <= it_neg_r[SQRT_STAGES-1];
      out_flag_r <= rnd_neg_r;
      for (int t = 0; t < NUM_TOWERS; t++) begin
        rnd_root_r[t] <= rnd_root_nxt[t];
        out_h_r[t]    <= out_h_nxt[t];
      end
    end
  end

  assign res_vld = out_vld_r;
  always_comb begin
    for (int t = 0; t < NUM_TOWERS; t++) begin
      res.carriage[t] = out_h_r[t];
    end
    res.unreachable = out_flag_r;
  end

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((!out_flag_r[TWR_A] || out_h_r[TWR_A] == '0) &&
                   (!out_flag_r[TWR_B] || out_h_r[TWR_B] == '0) &&
                   (!out_flag_r[TWR_C] || out_h_r[TWR_C] == '0)))
    else $error("unreachable tower with nonzero height");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_vld_r |-> (!rnd_root_r[TWR_A][ROOT_W] && !rnd_root_r[TWR_B][ROOT_W] &&
                   !rnd_root_r[TWR_C][ROOT_W]))
    else $error("rounded root overflow");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en && it_vld_r[SQRT_STAGES-1]) |=> rnd_vld_r)
    else $error("item lost between root and rounding stages");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && rnd_vld_r) |=> (rnd_vld_r && $stable(rnd_z_r) && $stable(rnd_neg_r)))
    else $error("rounding stage changed during stall");

endmodule

>>> bench/tb_delta_inverse_kinematics.sv
`timescale 1ns / 100ps

module tb_delta_inverse_kinematics;
  import dik_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } target_t;

  typedef struct {
    height_t a;
    height_t b;
    height_t c;
    flags_t  unreach;
  } carriage_set_t;

  logic clk;
  logic rst_n;

  dik_in_if  in_bus();
  dik_out_if out_bus();
  dik_cfg_if cfg_bus();

  delta_inverse_kinematics dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  target_t             pending_targets[$];
  carriage_set_t       expected_heights[$];
  target_t             next_target;
  carriage_set_t       want;
  logic [RADIUS_W-1:0] radius_q;
  logic [ROD_W-1:0]    rod_q;
  logic                in_taken;
  logic                hold_go;
  int                  hold_cnt;
  int                  in_idle_pct;
  int                  out_stall_pct;
  int                  mismatches;

  function automatic longint nearest_root(longint a);
    longint r;
    longint c;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= a) r = c;
    end
    if (a - r * r > r) r++;
    return r;
  endfunction

  function automatic carriage_set_t predict_heights(coord_t x, coord_t y, coord_t z);
    longint        xo;
    longint        yo;
    longint        rod2;
    longint        dx;
    longint        dy;
    longint        arg;
    longint        tx[NUM_TOWERS];
    longint        ty[NUM_TOWERS];
    height_t       h[NUM_TOWERS];
    carriage_set_t res;
    xo = (longint'(radius_q) * longint'(SIN60_Q16) + 32768) >>> 16;
    yo = (longint'(radius_q) + 1) >>> 1;
    rod2 = longint'(rod_q) * longint'(rod_q);
    tx[TWR_A] = -xo;
    ty[TWR_A] = -yo;
    tx[TWR_B] = xo;
    ty[TWR_B] = -yo;
    tx[TWR_C] = 0;
    ty[TWR_C] = longint'(radius_q);
    res.unreach = '0;
    for (int i = 0; i < NUM_TOWERS; i++) begin
      dx = tx[i] - longint'(x);
      dy = ty[i] - longint'(y);
      arg = rod2 - dx * dx - dy * dy;
      if (arg < 0) begin
        res.unreach[i] = 1'b1;
        h[i] = '0;
      end else begin
        h[i] = height_t'(nearest_root(arg) + longint'(z));
      end
    end
    res.a = h[TWR_A];
    res.b = h[TWR_B];
    res.c = h[TWR_C];
    return res;
  endfunction

  function automatic coord_t pick_coord(longint span);
    longint v;
    if (span > 65535) span = 65535;
    if (span < 1) span = 1;
    v = longint'($urandom_range(0, 2 * span)) - span;
    return coord_t'(v);
  endfunction

  task automatic add_target(longint x, longint y, longint z);
    target_t t;
    t.x = coord_t'(x);
    t.y = coord_t'(y);
    t.z = coord_t'(z);
    pending_targets.push_back(t);
  endtask

  // mostly targets in the rod's reach, the rest anywhere or within a rod length
  task automatic add_random_target(longint rod);
    target_t t;
    int      kind;
    kind = $urandom_range(9);
    t.z = coord_t'($urandom());
    if (kind < 6) begin
      t.x = pick_coord(rod / 2);
      t.y = pick_coord(rod / 2);
    end else if (kind < 8) begin
      t.x = coord_t'($urandom());
      t.y = coord_t'($urandom());
    end else begin
      t.x = pick_coord(rod);
      t.y = pick_coord(rod);
    end
    pending_targets.push_back(t);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, longint val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.addr  = idx;
    cfg_bus.data  = val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // hold until every transfer is through, then let the pipeline settle
  task automatic wait_drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_targets.size() != 0 || in_bus.valid || expected_heights.size() != 0);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_targets.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        next_target = pending_targets.pop_front();
        in_bus.target_x <= next_target.x;
        in_bus.target_y <= next_target.y;
        in_bus.target_z <= next_target.z;
        in_bus.valid    <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= rst_n && hold_cnt == 0 && $urandom_range(99) >= out_stall_pct;
  end

  always @(posedge clk) begin
    if (!rst_n) hold_cnt <= 0;
    else if (hold_go) hold_cnt <= 400;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      radius_q = RADIUS_RESET;
      rod_q    = ROD_RESET;
      in_taken = 1'b0;
    end else begin
      in_taken = in_bus.valid && in_bus.ready;
      if (in_taken)
        expected_heights.push_back(
          predict_heights(in_bus.target_x, in_bus.target_y, in_bus.target_z));
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.addr)
          REG_TOWER_RADIUS: radius_q = cfg_bus.data[RADIUS_W-1:0];
          REG_ROD_LENGTH:   rod_q    = cfg_bus.data[ROD_W-1:0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_heights.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = expected_heights.pop_front();
          if (out_bus.carriage_a !== want.a) begin
            $error("carriage_a: expected %0d, got %0d", want.a, out_bus.carriage_a);
            mismatches++;
          end
          if (out_bus.carriage_b !== want.b) begin
            $error("carriage_b: expected %0d, got %0d", want.b, out_bus.carriage_b);
            mismatches++;
          end
          if (out_bus.carriage_c !== want.c) begin
            $error("carriage_c: expected %0d, got %0d", want.c, out_bus.carriage_c);
            mismatches++;
          end
          if (out_bus.unreachable !== want.unreach) begin
            $error("unreachable: expected %b, got %b", want.unreach, out_bus.unreachable);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    longint twr_x;
    longint twr_y;
    longint rad;
    longint rod;
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.target_x = '0;
    in_bus.target_y = '0;
    in_bus.target_z = '0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.addr    = REG_TOWER_RADIUS;
    cfg_bus.data    = '0;
    hold_go         = 1'b0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    mismatches      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default geometry: field extremes, straight under a tower, far out of reach
    twr_x = (longint'(RADIUS_RESET) * longint'(SIN60_Q16) + 32768) >>> 16;
    twr_y = (longint'(RADIUS_RESET) + 1) >>> 1;
    add_target(0, 0, 0);
    add_target(65535, 65535, 65535);
    add_target(-65536, -65536, -65536);
    add_target(65535, -65536, 0);
    add_target(-65536, 65535, -1);
    add_target(-twr_x, -twr_y, 0);
    add_target(twr_x, -twr_y, -300);
    add_target(0, longint'(RADIUS_RESET), 100);
    wait_drain();

    // all towers at the origin: zero root argument on the rod circle
    write_reg(REG_TOWER_RADIUS, 0);
    write_reg(REG_ROD_LENGTH, 256);
    add_target(256, 0, -65536);
    add_target(0, -256, 65535);
    add_target(0, 0, 65535);
    add_target(257, 0, 0);
    wait_drain();

    write_reg(REG_TOWER_RADIUS, 65535);
    write_reg(REG_ROD_LENGTH, 131071);
    add_target(0, 0, 65535);
    add_target(0, 65535, 65535);
    add_target(0, 65535, -65536);
    add_target(-65536, -65536, 0);
    wait_drain();

    write_reg(REG_TOWER_RADIUS, 0);
    write_reg(REG_ROD_LENGTH, 0);
    add_target(0, 0, -65536);
    add_target(1, 0, 0);
    add_target(0, -1, 7);
    wait_drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        2: begin rad = 65535; rod = 131071; end
        3: begin rad = $urandom_range(0, 65535); rod = $urandom_range(0, 131071); end
        4: begin rad = 0; rod = $urandom_range(256, 131071); end
        5: begin rad = $urandom_range(1, 4096); rod = $urandom_range(1, 8192); end
        6: begin rad = $urandom_range(0, 65535); rod = 0; end
        default: begin rad = RADIUS_RESET; rod = ROD_RESET; end
      endcase
      write_reg(REG_TOWER_RADIUS, rad);
      write_reg(REG_ROD_LENGTH, rod);
      in_idle_pct   = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 16 : 0;
      out_stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 16 : 0;
      repeat (160) add_random_target(rod);
      if (ph == 0) begin
        // stall the sink long enough to back the pipeline up into the input
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
      end
      wait_drain();
    end

    if (mismatches == 0)
      $display("tb_delta_inverse_kinematics: PASS");
    else
      $display("tb_delta_inverse_kinematics: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_delta_inverse_kinematics: FAIL");
    $finish;
  end

endmodule
